FILE: rtl/dfe_pkg.sv
package dfe_pkg;

   localparam int BYTE_W       = 8;
   localparam int FIELD_IDX_W  = 8;
   localparam int MAX_LENGTH_W = 7;
   localparam int CSR_DATA_W   = 8;
   localparam int CSR_INDEX_W  = 1;

   localparam logic [CSR_INDEX_W-1:0] CSR_FIELD_INDEX = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_LENGTH  = 1'b1;

   localparam logic [FIELD_IDX_W-1:0]  FIELD_INDEX_RESET = 8'd0;
   localparam logic [MAX_LENGTH_W-1:0] MAX_LENGTH_RESET  = 7'd64;

   localparam logic [BYTE_W-1:0] SEP_CHAR   = 8'h7C;
   localparam logic [BYTE_W-1:0] SPACE_CHAR = 8'h20;
   localparam logic [BYTE_W-1:0] NUL_CHAR   = 8'h00;
   localparam logic [BYTE_W-1:0] TAB_CHAR   = 8'h09;
   localparam logic [BYTE_W-1:0] CR_CHAR    = 8'h0D;

   // parse position within the line
   typedef enum logic [3:0] {
      PH_SKIP = 4'b0001,
      PH_LEAD = 4'b0010,
      PH_COPY = 4'b0100,
      PH_DONE = 4'b1000
   } phase_type;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_READ = 2'b10
   } ctrl_state_type;

   typedef struct packed {
      logic byte_en;
      logic line_end;
      logic emit_empty;
      logic rd_en;
   } dfe_cmd_type;

   typedef struct packed {
      logic empty;
      logic rd_last;
   } dfe_status_type;

   function automatic logic is_blank(input logic [BYTE_W-1:0] c);
      return (c == SPACE_CHAR) || ((c >= TAB_CHAR) && (c <= CR_CHAR));
   endfunction

endpackage

FILE: rtl/delimited_field_extractor.sv
// Extracts one '|'-separated field from a line fed one byte per item, with
// leading and trailing whitespace trimmed. Byte items leave busy low, so a
// byte can be started every cycle. An end-of-line item with n trimmed bytes
// stored raises busy while the field store is read through its single read
// port, one byte per cycle. Each read reaches the result ports in the cycle
// after it. rsp_last_byte marks the final result, which shows in the first
// cycle with busy low again. A missing or blank field gives a single result
// with rsp_found low, in the cycle after the end item, without raising busy.
// There is no output back-pressure: every rsp_valid cycle carries a result
// that must be taken.
module delimited_field_extractor #(
   parameter int MAX_FIELD = 64
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [dfe_pkg::BYTE_W-1:0]          req_line_byte,
   input  logic                                req_end_of_line,
   output logic                                rsp_valid,
   output logic [dfe_pkg::BYTE_W-1:0]          rsp_field_byte,
   output logic                                rsp_found,
   output logic                                rsp_last_byte,
   input  logic                                csr_write_en,
   input  logic [dfe_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [dfe_pkg::CSR_DATA_W-1:0]      csr_write_data
);

   dfe_pkg::dfe_cmd_type    cmd;
   dfe_pkg::dfe_status_type status;

   dfe_ctrl u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .req_end_of_line (req_end_of_line),
      .status          (status),
      .cmd             (cmd),
      .busy            (busy)
   );

   dfe_datapath #(
      .MAX_FIELD (MAX_FIELD)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .req_line_byte  (req_line_byte),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data),
      .rsp_valid      (rsp_valid),
      .rsp_field_byte (rsp_field_byte),
      .rsp_found      (rsp_found),
      .rsp_last_byte  (rsp_last_byte)
   );

   // a not-found item is the only one for its line and carries a zero byte
   a_not_found_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_found |-> rsp_last_byte && (rsp_field_byte == '0))
      else $error("not-found item is not a lone zero item");

   // the final byte of a burst shows once the read sequence has finished
   a_last_ends_burst: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_found && rsp_last_byte |-> !busy)
      else $error("last item while still reading");

   // an end item either gives a result at once or starts the read burst
   a_eol_responds: assert property (@(posedge clock) disable iff (reset)
      start && !busy && req_end_of_line |=> rsp_valid || busy)
      else $error("end item with no response");

   // leaving the burst coincides with the last item
   a_burst_closes: assert property (@(posedge clock) disable iff (reset)
      $fell(busy) && !$past(reset) |-> rsp_valid && rsp_last_byte)
      else $error("burst ended without a last item");

endmodule

FILE: rtl/dfe_ctrl.sv
module dfe_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic                    req_end_of_line,
   input  dfe_pkg::dfe_status_type status,
   output dfe_pkg::dfe_cmd_type    cmd,
   output logic                    busy
);

   dfe_pkg::ctrl_state_type state_ff, state_in;
   logic accept;

   assign busy   = (state_ff == dfe_pkg::ST_READ);
   assign accept = start && !busy;

   always_comb begin
      state_in       = state_ff;
      cmd.byte_en    = 1'b0;
      cmd.line_end   = 1'b0;
      cmd.emit_empty = 1'b0;
      cmd.rd_en      = 1'b0;
      case (state_ff)
         dfe_pkg::ST_IDLE: begin
            cmd.byte_en  = accept && !req_end_of_line;
            cmd.line_end = accept && req_end_of_line;
            if (accept && req_end_of_line) begin
               if (status.empty) begin
                  cmd.emit_empty = 1'b1;
               end else begin
                  state_in = dfe_pkg::ST_READ;
               end
            end
         end
         dfe_pkg::ST_READ: begin
            cmd.rd_en = 1'b1;
            if (status.rd_last) begin
               state_in = dfe_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = dfe_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= dfe_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

FILE: rtl/dfe_datapath.sv
module dfe_datapath #(
   parameter int MAX_FIELD = 64
) (
   input  logic                                clock,
   input  logic                                reset,
   input  dfe_pkg::dfe_cmd_type                cmd,
   output dfe_pkg::dfe_status_type             status,
   input  logic [dfe_pkg::BYTE_W-1:0]          req_line_byte,
   input  logic                                csr_write_en,
   input  logic [dfe_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [dfe_pkg::CSR_DATA_W-1:0]      csr_write_data,
   output logic                                rsp_valid,
   output logic [dfe_pkg::BYTE_W-1:0]          rsp_field_byte,
   output logic                                rsp_found,
   output logic                                rsp_last_byte
);

   localparam int AW = $clog2(MAX_FIELD);
   localparam logic [dfe_pkg::MAX_LENGTH_W-1:0] MaxFieldLen =
      dfe_pkg::MAX_LENGTH_W'(MAX_FIELD);

   logic [dfe_pkg::FIELD_IDX_W-1:0]  field_index_ff;
   logic [dfe_pkg::MAX_LENGTH_W-1:0] max_length_ff;

   dfe_pkg::phase_type              phase_ff, phase_in;
   logic [dfe_pkg::FIELD_IDX_W-1:0] sep_count_ff, sep_count_in;
   logic [AW-1:0]                   stored_ff, stored_in;
   logic [AW-1:0]                   trimmed_ff, trimmed_in;
   logic [AW-1:0]                   count_ff, count_in;
   logic [AW-1:0]                   rd_addr_ff, rd_addr_in;

   logic [dfe_pkg::BYTE_W-1:0] field_store [MAX_FIELD];
   logic [dfe_pkg::BYTE_W-1:0] rdata_ff;
   logic                       valid_ff, found_ff, last_ff;

   logic [dfe_pkg::MAX_LENGTH_W-1:0] limit;
   logic [AW-1:0]                    keep_limit;
   logic                             wr_en;
   logic                             c_sep, c_blank;

   assign c_sep   = (req_line_byte == dfe_pkg::SEP_CHAR);
   assign c_blank = dfe_pkg::is_blank(req_line_byte);

   // min(max_length, MAX_FIELD) - 1, floored at zero
   always_comb begin
      limit = (max_length_ff > MaxFieldLen) ? MaxFieldLen : max_length_ff;
      if (limit == '0) begin
         keep_limit = '0;
      end else begin
         keep_limit = AW'(limit - 1'b1);
      end
   end

   assign status.empty   = (trimmed_ff == '0);
   assign status.rd_last = (({1'b0, rd_addr_ff} + 1'b1) == {1'b0, count_ff});

   always_comb begin
      dfe_pkg::phase_type work;
      work         = phase_ff;
      phase_in     = phase_ff;
      sep_count_in = sep_count_ff;
      stored_in    = stored_ff;
      trimmed_in   = trimmed_ff;
      count_in     = count_ff;
      rd_addr_in   = rd_addr_ff;
      wr_en        = 1'b0;
      if (cmd.line_end) begin
         phase_in     = dfe_pkg::PH_SKIP;
         sep_count_in = '0;
         stored_in    = '0;
         trimmed_in   = '0;
         count_in     = trimmed_ff;
         rd_addr_in   = '0;
      end else if (cmd.byte_en) begin
         if (req_line_byte == dfe_pkg::NUL_CHAR) begin
            // a zero byte ends the line content
            phase_in = dfe_pkg::PH_DONE;
         end else begin
            if (work == dfe_pkg::PH_SKIP) begin
               if (sep_count_ff >= field_index_ff) begin
                  work     = dfe_pkg::PH_LEAD;
                  phase_in = dfe_pkg::PH_LEAD;
               end else if (c_sep) begin
                  sep_count_in = sep_count_ff + 1'b1;
               end
            end
            if (work == dfe_pkg::PH_LEAD) begin
               if (c_sep) begin
                  phase_in = dfe_pkg::PH_DONE;
               end else if (!c_blank) begin
                  work = dfe_pkg::PH_COPY;
               end
            end
            if (work == dfe_pkg::PH_COPY) begin
               phase_in = dfe_pkg::PH_COPY;
               if (c_sep) begin
                  phase_in = dfe_pkg::PH_DONE;
               end else if (stored_ff < keep_limit) begin
                  wr_en     = 1'b1;
                  stored_in = stored_ff + 1'b1;
                  if (!c_blank) begin
                     trimmed_in = stored_ff + 1'b1;
                  end
               end
            end
         end
      end
      if (cmd.rd_en) begin
         rd_addr_in = rd_addr_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         field_index_ff <= dfe_pkg::FIELD_INDEX_RESET;
         max_length_ff  <= dfe_pkg::MAX_LENGTH_RESET;
         phase_ff       <= dfe_pkg::PH_SKIP;
         sep_count_ff   <= '0;
         stored_ff      <= '0;
         trimmed_ff     <= '0;
         count_ff       <= '0;
         rd_addr_ff     <= '0;
         valid_ff       <= 1'b0;
         found_ff       <= 1'b0;
         last_ff        <= 1'b0;
      end else begin
         if (csr_write_en) begin
            case (csr_index)
               dfe_pkg::CSR_FIELD_INDEX: begin
                  field_index_ff <= csr_write_data;
               end
               dfe_pkg::CSR_MAX_LENGTH: begin
                  max_length_ff <= csr_write_data[dfe_pkg::MAX_LENGTH_W-1:0];
               end
               default: begin
                  field_index_ff <= field_index_ff;
               end
            endcase
         end
         phase_ff     <= phase_in;
         sep_count_ff <= sep_count_in;
         stored_ff    <= stored_in;
         trimmed_ff   <= trimmed_in;
         count_ff     <= count_in;
         rd_addr_ff   <= rd_addr_in;
         valid_ff     <= cmd.rd_en || cmd.emit_empty;
         found_ff     <= cmd.rd_en;
         last_ff      <= cmd.emit_empty || (cmd.rd_en && status.rd_last);
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         field_store[stored_ff] <= req_line_byte;
      end
      if (cmd.rd_en) begin
         rdata_ff <= field_store[rd_addr_ff];
      end
   end

   assign rsp_valid      = valid_ff;
   assign rsp_found      = found_ff;
   assign rsp_last_byte  = last_ff;
   assign rsp_field_byte = found_ff ? rdata_ff : '0;

endmodule
